// ===== hw/rtl/cube_direction_to_face_uv_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cube direction to face/uv block
// Shared concurrent assertion forms, clocked on clock; the implication forms are reset on reset.
// ----------------------------------------------------------------------------
`ifndef CUBE_DIRECTION_TO_FACE_UV_MACROS_SVH
`define CUBE_DIRECTION_TO_FACE_UV_MACROS_SVH

// Same-cycle implication, off during reset
`define CDFU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define CDFU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check that holds in the cycle after reset was seen high
`define CDFU_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cdfu_pkg.sv =====
// ----------------------------------------------------------------------------
// cdfu_pkg
// Widths, face codes and pipeline payload types for the cube face/uv block.
// ----------------------------------------------------------------------------
package cdfu_pkg;

   // Direction component and face coordinate widths
   localparam int COMP_W    = 16;
   localparam int UV_FRAC_W = 16;
   localparam int FACE_W    = 3;

   // Divider: quotient bits resolved per pipeline stage
   localparam int DIV_STEP_N = 4;
   localparam int DIV_STAGES = (UV_FRAC_W + DIV_STEP_N - 1) / DIV_STEP_N;
   localparam int DIV_BITS   = DIV_STAGES * DIV_STEP_N;

   localparam logic [UV_FRAC_W-1:0] UV_CENTER = {1'b1, {(UV_FRAC_W-1){1'b0}}};
   localparam logic [UV_FRAC_W-1:0] UV_MAX    = {UV_FRAC_W{1'b1}};

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // How a coordinate is finished at the output
   typedef enum logic [1:0] {
      UV_MODE_DIV,
      UV_MODE_SAT,
      UV_MODE_MID
   } uv_mode_type;

   // After face selection
   typedef struct packed {
      face_type                 face;
      logic [COMP_W-1:0]        major;
      logic signed [COMP_W:0]   minor_u;
      logic signed [COMP_W:0]   minor_v;
   } sel_word_type;

   // One divider lane: partial remainder and quotient so far
   typedef struct packed {
      logic [COMP_W:0]   rem;
      logic [DIV_BITS-1:0] quo;
      uv_mode_type       mode;
   } div_lane_type;

   typedef struct packed {
      face_type          face;
      logic [COMP_W-1:0] major;
      div_lane_type      lane_u;
      div_lane_type      lane_v;
   } div_word_type;

endpackage

// ===== hw/rtl/cdfu_channels.sv =====
// ----------------------------------------------------------------------------
// cdfu channel interfaces
// Valid/ready channels for direction items in and face/uv items out.
// ----------------------------------------------------------------------------
interface cdfu_req_if;
   import cdfu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] dir_x;
   logic signed [COMP_W-1:0] dir_y;
   logic signed [COMP_W-1:0] dir_z;

   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cdfu_rsp_if;
   import cdfu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FACE_W-1:0]    face;
   logic [UV_FRAC_W-1:0] image_u;
   logic [UV_FRAC_W-1:0] image_v;

   modport source (output valid, output face, output image_u, output image_v, input ready);
   modport sink   (input valid, input face, input image_u, input image_v, output ready);
endinterface

// ===== hw/rtl/cdfu_select_stage.sv =====
// ----------------------------------------------------------------------------
// cdfu_select_stage
// Picks the cube face by largest magnitude and the signed minor components.
// ----------------------------------------------------------------------------
module cdfu_select_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             up_valid,
   output logic                             up_ready,
   input  logic signed [cdfu_pkg::COMP_W-1:0] dir_x,
   input  logic signed [cdfu_pkg::COMP_W-1:0] dir_y,
   input  logic signed [cdfu_pkg::COMP_W-1:0] dir_z,
   output logic                             dn_valid,
   input  logic                             dn_ready,
   output cdfu_pkg::sel_word_type           dn_data
);
   import cdfu_pkg::*;

   logic signed [COMP_W:0] x_ext, y_ext, z_ext;
   logic signed [COMP_W:0] x_neg, y_neg, z_neg;
   logic [COMP_W:0]        ax_full, ay_full, az_full;
   logic [COMP_W-1:0]      ax, ay, az;
   sel_word_type           word_in, word_ff;
   logic                   valid_in, valid_ff;

   // Widen by one bit so the most negative value negates exactly
   always_comb begin
      x_ext   = {dir_x[COMP_W-1], dir_x};
      y_ext   = {dir_y[COMP_W-1], dir_y};
      z_ext   = {dir_z[COMP_W-1], dir_z};
      x_neg   = -x_ext;
      y_neg   = -y_ext;
      z_neg   = -z_ext;
      ax_full = x_ext[COMP_W] ? x_neg : x_ext;
      ay_full = y_ext[COMP_W] ? y_neg : y_ext;
      az_full = z_ext[COMP_W] ? z_neg : z_ext;
      ax      = ax_full[COMP_W-1:0];
      ay      = ay_full[COMP_W-1:0];
      az      = az_full[COMP_W-1:0];
   end

   // Select face: x wins ties over y, y over z; zero or more is the positive face
   always_comb begin
      word_in = word_ff;
      if (ax >= ay && ax >= az) begin
         word_in.major   = ax;
         word_in.minor_v = y_neg;
         if (!x_ext[COMP_W]) begin
            word_in.face    = FACE_POS_X;
            word_in.minor_u = z_neg;
         end else begin
            word_in.face    = FACE_NEG_X;
            word_in.minor_u = z_ext;
         end
      end else if (ay >= az) begin
         word_in.major   = ay;
         word_in.minor_u = x_ext;
         if (!y_ext[COMP_W]) begin
            word_in.face    = FACE_POS_Y;
            word_in.minor_v = z_ext;
         end else begin
            word_in.face    = FACE_NEG_Y;
            word_in.minor_v = z_neg;
         end
      end else begin
         word_in.major   = az;
         word_in.minor_v = y_neg;
         if (!z_ext[COMP_W]) begin
            word_in.face    = FACE_POS_Z;
            word_in.minor_u = x_ext;
         end else begin
            word_in.face    = FACE_NEG_Z;
            word_in.minor_u = x_neg;
         end
      end
   end

   // Advance when the stage is empty or its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = word_ff;

endmodule

// ===== hw/rtl/cdfu_prep_stage.sv =====
// ----------------------------------------------------------------------------
// cdfu_prep_stage
// Forms the divider numerators and flags the saturated and centered cases.
// ----------------------------------------------------------------------------
module cdfu_prep_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cdfu_pkg::sel_word_type up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output cdfu_pkg::div_word_type dn_data
);
   import cdfu_pkg::*;

   div_word_type word_in, word_ff;
   logic         valid_in, valid_ff;

   // Numerator m + s, never below zero since |s| <= m
   function automatic div_lane_type prep_lane(logic signed [COMP_W:0] minor,
                                              logic [COMP_W-1:0] major);
      logic signed [COMP_W+1:0] num;
      logic [COMP_W:0]          num_pos;
      div_lane_type             lane;
      num     = $signed({2'b00, major}) + $signed({minor[COMP_W], minor});
      num_pos = num[COMP_W+1] ? '0 : num[COMP_W:0];
      lane.rem = num_pos;
      lane.quo = '0;
      if (major == '0) begin
         lane.mode = UV_MODE_MID;
      end else if (num_pos >= {major, 1'b0}) begin
         lane.mode = UV_MODE_SAT;
      end else begin
         lane.mode = UV_MODE_DIV;
      end
      return lane;
   endfunction

   always_comb begin
      word_in.face   = up_data.face;
      word_in.major  = up_data.major;
      word_in.lane_u = prep_lane(up_data.minor_u, up_data.major);
      word_in.lane_v = prep_lane(up_data.minor_v, up_data.major);
   end

   // Advance when the stage is empty or its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = word_ff;

endmodule

// ===== hw/rtl/cdfu_div_stage.sv =====
// ----------------------------------------------------------------------------
// cdfu_div_stage
// One stage of the restoring divider: DIV_STEP_N quotient bits per lane.
// ----------------------------------------------------------------------------
module cdfu_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cdfu_pkg::div_word_type up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output cdfu_pkg::div_word_type dn_data
);
   import cdfu_pkg::*;

   div_word_type word_in, word_ff;
   logic         valid_in, valid_ff;

   // Compare, subtract, shift: one quotient bit per step
   function automatic div_lane_type div_steps(div_lane_type lane, logic [COMP_W-1:0] major);
      logic [COMP_W:0]     rem;
      logic [DIV_BITS-1:0] quo;
      logic [COMP_W:0]     major_x;
      logic                bit_q;
      div_lane_type        res;
      rem     = lane.rem;
      quo     = lane.quo;
      major_x = {1'b0, major};
      for (int k = 0; k < DIV_STEP_N; k++) begin
         bit_q = (rem >= major_x);
         if (bit_q) begin
            rem = rem - major_x;
         end
         rem = {rem[COMP_W-1:0], 1'b0};
         quo = {quo[DIV_BITS-2:0], bit_q};
      end
      res.rem  = rem;
      res.quo  = quo;
      res.mode = lane.mode;
      return res;
   endfunction

   always_comb begin
      word_in.face   = up_data.face;
      word_in.major  = up_data.major;
      word_in.lane_u = div_steps(up_data.lane_u, up_data.major);
      word_in.lane_v = div_steps(up_data.lane_v, up_data.major);
   end

   // Advance when the stage is empty or its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = word_ff;

endmodule

// ===== hw/rtl/cdfu_out_stage.sv =====
// ----------------------------------------------------------------------------
// cdfu_out_stage
// Finishes each coordinate (quotient, saturation or center) into the output.
// ----------------------------------------------------------------------------
module cdfu_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  cdfu_pkg::div_word_type            up_data,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [cdfu_pkg::FACE_W-1:0]       dn_face,
   output logic [cdfu_pkg::UV_FRAC_W-1:0]    dn_image_u,
   output logic [cdfu_pkg::UV_FRAC_W-1:0]    dn_image_v
);
   import cdfu_pkg::*;

   logic [FACE_W-1:0]    face_in, face_ff;
   logic [UV_FRAC_W-1:0] u_in, u_ff;
   logic [UV_FRAC_W-1:0] v_in, v_ff;
   logic                 valid_in, valid_ff;

   // Drop the extra trailing quotient bits; floor of a floor stays exact
   function automatic logic [UV_FRAC_W-1:0] finish(div_lane_type lane);
      logic [UV_FRAC_W-1:0] res;
      case (lane.mode)
         UV_MODE_DIV: res = lane.quo[DIV_BITS-1 -: UV_FRAC_W];
         UV_MODE_SAT: res = UV_MAX;
         UV_MODE_MID: res = UV_CENTER;
         default:     res = UV_CENTER;
      endcase
      return res;
   endfunction

   always_comb begin
      face_in = up_data.face;
      u_in    = finish(up_data.lane_u);
      v_in    = finish(up_data.lane_v);
   end

   // Hold a result while the sink stalls, take a new item once it leaves
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         face_ff <= face_in;
         u_ff    <= u_in;
         v_ff    <= v_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_face    = face_ff;
   assign dn_image_u = u_ff;
   assign dn_image_v = v_ff;

endmodule

// ===== hw/rtl/cube_direction_to_face_uv.sv =====
// ----------------------------------------------------------------------------
// cube_direction_to_face_uv
// Cube-map face selection and Q0.16 face coordinate projection, pipelined.
// ----------------------------------------------------------------------------
// Pipeline: seven register stages (select, prep, four divider stages of four quotient
//   bits each, output) lie between an accepted item and its result.
// Throughput: one item per cycle while the sink takes results; the divider is fully pipelined per stage.
// Stalls collapse bubbles: each stage takes an item when empty or draining.
// Reset: synchronous, clears every stage valid bit; no payload is cleared.
module cube_direction_to_face_uv (
   input  logic        clock,
   input  logic        reset,
   cdfu_req_if.sink    req_chan,
   cdfu_rsp_if.source  rsp_chan
);
   import cdfu_pkg::*;

   sel_word_type      sel_data;
   logic              sel_valid, sel_ready;
   div_word_type      div_data [DIV_STAGES+1];
   logic [DIV_STAGES:0] div_valid;
   logic [DIV_STAGES:0] div_ready;

   // Face selection
   cdfu_select_stage u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .dir_x    (req_chan.dir_x),
      .dir_y    (req_chan.dir_y),
      .dir_z    (req_chan.dir_z),
      .dn_valid (sel_valid),
      .dn_ready (sel_ready),
      .dn_data  (sel_data)
   );

   // Numerators and special cases
   cdfu_prep_stage u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sel_valid),
      .up_ready (sel_ready),
      .up_data  (sel_data),
      .dn_valid (div_valid[0]),
      .dn_ready (div_ready[0]),
      .dn_data  (div_data[0])
   );

   // Divider pipeline
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      cdfu_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[i]),
         .up_ready (div_ready[i]),
         .up_data  (div_data[i]),
         .dn_valid (div_valid[i+1]),
         .dn_ready (div_ready[i+1]),
         .dn_data  (div_data[i+1])
      );
   end

   // Output register
   cdfu_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (div_valid[DIV_STAGES]),
      .up_ready   (div_ready[DIV_STAGES]),
      .up_data    (div_data[DIV_STAGES]),
      .dn_valid   (rsp_chan.valid),
      .dn_ready   (rsp_chan.ready),
      .dn_face    (rsp_chan.face),
      .dn_image_u (rsp_chan.image_u),
      .dn_image_v (rsp_chan.image_v)
   );

endmodule

// ===== hw/rtl/cdfu_checker.sv =====
// ----------------------------------------------------------------------------
// cdfu_checker
// Port-level checks on the cube face/uv block, bound to the top level.
// ----------------------------------------------------------------------------
`include "cube_direction_to_face_uv_macros.svh"

module cdfu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cdfu_pkg::FACE_W-1:0]       rsp_face,
   input logic [cdfu_pkg::UV_FRAC_W-1:0]    rsp_image_u,
   input logic [cdfu_pkg::UV_FRAC_W-1:0]    rsp_image_v
);
   import cdfu_pkg::*;

   // Only six faces exist
   `CDFU_ASSERT_IMP(a_face_range, rsp_valid, rsp_face <= FACE_NEG_Z, "face code out of range")

   // Input stalls only when every stage is full and the output is stalled
   `CDFU_ASSERT_IMP(a_stall_source, !req_ready, rsp_valid && !rsp_ready, "input stalled with room in pipe")

   // A stalled result holds
   `CDFU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_face) && $stable(rsp_image_u) && $stable(rsp_image_v), "stalled result changed")

   // Reset empties the pipeline
   `CDFU_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule

bind cube_direction_to_face_uv cdfu_checker u_cdfu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_face    (rsp_chan.face),
   .rsp_image_u (rsp_chan.image_u),
   .rsp_image_v (rsp_chan.image_v)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cube face/uv block. Each direction item sent in
// is run through a predictor of face selection and exact floor division. The
// expected face and coordinates are queued and checked against every result.
// A directed set comes first, then random directions. Idling on both sides
// changes by phase, and there is one long output hold-off and two input drains.
// ----------------------------------------------------------------------------
module testbench;
   import cdfu_pkg::*;

   localparam int RAND_ITEMS    = 1500;
   localparam int PHASE_LEN     = 150;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_LEN      = 150;
   localparam int DRAIN_AT      = 800;
   localparam int SETTLE_CYCLES = 4 * (3 + DIV_STAGES);
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 100;

   localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
   localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

   typedef enum int unsigned {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic signed [COMP_W-1:0] dir_x;
      logic signed [COMP_W-1:0] dir_y;
      logic signed [COMP_W-1:0] dir_z;
      idle_mode_type            mode;
      bit                       drain_first;
   } dir_item_type;

   typedef struct {
      face_type             face;
      logic [UV_FRAC_W-1:0] image_u;
      logic [UV_FRAC_W-1:0] image_v;
   } face_uv_type;

   logic clock = 1'b0;
   logic reset;

   cdfu_req_if req_bus ();
   cdfu_rsp_if rsp_bus ();

   cube_direction_to_face_uv u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   dir_item_type  dir_queue[$];
   face_uv_type   face_uv_queue[$];
   dir_item_type  cur_dir;
   idle_mode_type cur_mode = IDLE_NONE;
   int unsigned   sent_count = 0;
   int unsigned   recv_count = 0;
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   hold_left;
   bit            hold_done;
   bit            offer_next;
   int unsigned   send_roll;
   int unsigned   recv_roll;
   face_uv_type   want;

   // Free-running clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Map a ratio s/m to a Q0.F coordinate, floor, saturating at full scale
   function automatic logic [UV_FRAC_W-1:0] project_coord(input longint s, input longint m);
      longint num;
      longint q;
      if (m == 0)
         return UV_CENTER;
      num = ((s < 0) && (-s >= m)) ? 0 : m + s;
      q = (num << (UV_FRAC_W - 1)) / m;
      if (q > longint'(UV_MAX))
         q = longint'(UV_MAX);
      return q[UV_FRAC_W-1:0];
   endfunction

   // Pick the face by largest magnitude (x over y over z) and project the minors
   function automatic face_uv_type predict_face_uv(input dir_item_type d);
      longint x, y, z, ax, ay, az, su, sv, m;
      face_uv_type r;
      x = d.dir_x;
      y = d.dir_y;
      z = d.dir_z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      if (ax >= ay && ax >= az) begin
         m = ax;
         if (x >= 0) begin
            r.face = FACE_POS_X; su = -z; sv = -y;
         end else begin
            r.face = FACE_NEG_X; su = z;  sv = -y;
         end
      end else if (ay >= az) begin
         m = ay;
         if (y >= 0) begin
            r.face = FACE_POS_Y; su = x; sv = z;
         end else begin
            r.face = FACE_NEG_Y; su = x; sv = -z;
         end
      end else begin
         m = az;
         if (z >= 0) begin
            r.face = FACE_POS_Z; su = x;  sv = -y;
         end else begin
            r.face = FACE_NEG_Z; su = -x; sv = -y;
         end
      end
      r.image_u = project_coord(su, m);
      r.image_v = project_coord(sv, m);
      return r;
   endfunction

   // Full range mostly, with small values and the extremes mixed in
   function automatic logic signed [COMP_W-1:0] random_component();
      int unsigned kind;
      kind = $urandom_range(9);
      if (kind <= 5)
         return COMP_W'($urandom());
      if (kind <= 7)
         return COMP_W'(int'($urandom_range(16)) - 8);
      if (kind == 8) begin
         case ($urandom_range(3))
            0: return COMP_MIN;
            1: return COMP_W'(COMP_MIN + 1);
            2: return COMP_MAX;
            default: return '1;
         endcase
      end
      return '0;
   endfunction

   task automatic add_dir(input int x, input int y, input int z, input idle_mode_type mode,
                          input bit drain_first);
      dir_item_type d;
      d.dir_x = COMP_W'(x);
      d.dir_y = COMP_W'(y);
      d.dir_z = COMP_W'(z);
      d.mode = mode;
      d.drain_first = drain_first;
      dir_queue.push_back(d);
   endtask

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Driver: record accepted items, then offer the next one from the queue
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            face_uv_queue.push_back(predict_face_uv(cur_dir));
            sent_count <= sent_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            offer_next = 1'b0;
            if (dir_queue.size() != 0) begin
               send_roll = $urandom_range(99);
               // hold a drain item until every result is back
               if (dir_queue[0].drain_first && face_uv_queue.size() != 0)
                  offer_next = 1'b0;
               else
                  offer_next = !((dir_queue[0].mode == IDLE_SENDER && send_roll < 57) ||
                                 (dir_queue[0].mode == IDLE_BOTH && send_roll < 28));
            end
            if (offer_next) begin
               cur_dir = dir_queue.pop_front();
               req_bus.dir_x <= cur_dir.dir_x;
               req_bus.dir_y <= cur_dir.dir_y;
               req_bus.dir_z <= cur_dir.dir_z;
               cur_mode <= cur_dir.mode;
            end
            req_bus.valid <= offer_next;
         end
      end
   end

   // Long output hold-off, started once the stream is well under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each result against the oldest expectation, then set ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (face_uv_queue.size() == 0) begin
               report_error($sformatf("result %0d with no item pending: face %0d u %0d v %0d",
                                      recv_count, rsp_bus.face, rsp_bus.image_u,
                                      rsp_bus.image_v));
            end else begin
               want = face_uv_queue.pop_front();
               if (rsp_bus.face !== want.face)
                  report_error($sformatf("result %0d face got %0d expected %0d",
                                         recv_count, rsp_bus.face, want.face));
               if (rsp_bus.image_u !== want.image_u)
                  report_error($sformatf("result %0d image_u got %0d expected %0d",
                                         recv_count, rsp_bus.image_u, want.image_u));
               if (rsp_bus.image_v !== want.image_v)
                  report_error($sformatf("result %0d image_v got %0d expected %0d",
                                         recv_count, rsp_bus.image_v, want.image_v));
            end
            recv_count++;
         end
         recv_roll = $urandom_range(99);
         rsp_bus.ready <= (hold_left == 0) &&
                          !((cur_mode == IDLE_RECEIVER && recv_roll < 57) ||
                            (cur_mode == IDLE_BOTH && recv_roll < 28));
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      logic signed [COMP_W-1:0] x, y, z;
      idle_mode_type mode;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      req_bus.dir_z = '0;
      rsp_bus.ready = 1'b0;

      // zero vector, axis extremes, ties, saturation and rounding
      add_dir(0, 0, 0, IDLE_NONE, 1'b0);
      add_dir(COMP_MAX, 0, 0, IDLE_NONE, 1'b0);
      add_dir(COMP_MIN, 0, 0, IDLE_NONE, 1'b0);
      add_dir(0, COMP_MAX, 0, IDLE_NONE, 1'b0);
      add_dir(0, COMP_MIN, 0, IDLE_NONE, 1'b0);
      add_dir(0, 0, COMP_MAX, IDLE_NONE, 1'b0);
      add_dir(0, 0, COMP_MIN, IDLE_NONE, 1'b0);
      add_dir(100, 100, 100, IDLE_NONE, 1'b0);
      add_dir(-100, 100, 100, IDLE_NONE, 1'b0);
      add_dir(0, 100, 100, IDLE_NONE, 1'b0);
      add_dir(0, -100, 100, IDLE_NONE, 1'b0);
      add_dir(0, -100, -100, IDLE_NONE, 1'b0);
      add_dir(100, -100, -100, IDLE_NONE, 1'b0);
      add_dir(100, 100, 100, IDLE_NONE, 1'b0);
      add_dir(COMP_MIN, COMP_MIN, COMP_MIN, IDLE_NONE, 1'b0);
      add_dir(COMP_MIN, COMP_MAX, COMP_MIN, IDLE_NONE, 1'b0);
      add_dir(COMP_MAX, COMP_MIN, 0, IDLE_NONE, 1'b0);
      add_dir(COMP_MAX, COMP_MAX, COMP_MIN, IDLE_NONE, 1'b0);
      add_dir(1, 0, 0, IDLE_NONE, 1'b0);
      add_dir(-1, 1, -1, IDLE_NONE, 1'b0);
      add_dir(3, 1, -1, IDLE_NONE, 1'b0);
      add_dir(7, -3, 2, IDLE_NONE, 1'b0);
      add_dir(1, 2, -5, IDLE_NONE, 1'b0);
      add_dir(-3, 4, 9, IDLE_NONE, 1'b0);
      add_dir(-6, 5, -7, IDLE_NONE, 1'b0);

      // random directions, idling mode stepping every phase
      for (int i = 0; i < RAND_ITEMS; i++) begin
         x = random_component();
         y = random_component();
         z = random_component();
         // force ties now and then
         case ($urandom_range(7))
            0: y = $urandom_range(1) ? x : -x;
            1: z = $urandom_range(1) ? y : -y;
            2: z = $urandom_range(1) ? x : -x;
            default: ;
         endcase
         mode = idle_mode_type'((i / PHASE_LEN) % 4);
         add_dir(int'(x), int'(y), int'(z), mode, (i == 0) || (i == DRAIN_AT));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for all items out and all results back, then let the pipe settle
      do
         @(negedge clock);
      while (dir_queue.size() != 0 || req_bus.valid || face_uv_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
